// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the centred moving average block.
// Each macro expands to one labelled concurrent assertion on the given clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cma_pkg.sv =====
// Shared types and constants of the centred moving average block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cma_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 6;
  localparam int WINDOW_MAX     = (1 << CFG_W) - 1;
  localparam int MAX_WINDOW_DEF = 32;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd5;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] average;
    logic                     last_average;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic store;
    logic sum_start;
    logic read_en;
    logic add_en;
    logic div_start;
    logic load_out;
    logic pass_sel;
    logic out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== design/centered_moving_average.sv =====
// Top level of the centred moving average: configuration register, controller
// and datapath. Depends on cma_pkg, cma_ctrl, cma_datapath and assert_macros.svh.
//
//   Channel   Direction  Handshake                  Carries
//   item      in         item_valid / item_ready    sample, last_sample
//   result    out        result_valid / result_ready average, last_average
//   config    in         psel, penable, pwrite      window_length at byte 0
//
// An averaged result is loaded into the output register, once that is free, after its
// window is summed and divided: the sum reads one store entry per cycle and the divider
// retires one quotient bit per cycle. The final sample of a sequence produces its pending
// results in turn, and the next request can be taken in the cycle after the last of them
// is loaded. A pass-through result, for a window of one or less, is loaded from the
// captured sample once the output register is free. A new request is taken while a
// result still waits in the output register.
`default_nettype none
`include "assert_macros.svh"

module centered_moving_average #(
  parameter int MAX_WINDOW = cma_pkg::MAX_WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cma_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cma_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cma_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  cma_pkg::in_item_t                item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output cma_pkg::out_item_t               result
);
  import cma_pkg::*;

  localparam int WMAX  = (MAX_WINDOW < WINDOW_MAX) ? MAX_WINDOW : WINDOW_MAX;
  localparam int CNT_W = $clog2(WMAX + 1);
  localparam int SUM_W = DATA_W + $clog2(WMAX);

  logic [CFG_W-1:0]     window_length;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;
  dp_cmd_t              cmd;
  dp_status_t           status;
  logic [CNT_W-1:0]     div_count;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && (reg_idx == REG_WINDOW_LENGTH);
  assign prdata    = (reg_idx == REG_WINDOW_LENGTH) ? APB_DATA_W'(window_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (cfg_write) begin
      window_length <= pwdata[CFG_W-1:0];
    end
  end

  cma_ctrl #(
    .MAX_WINDOW (MAX_WINDOW),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .window_length (window_length),
    .cfg_write     (cfg_write),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item_last     (item.last_sample),
    .status        (status),
    .cmd           (cmd),
    .div_count     (div_count)
  );

  cma_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .div_count    (div_count),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  `ASSERT_IMPL(a_load_when_free, clk, rst, cmd.load_out, status.out_free, "result loaded over a held one")
  `ASSERT_IMPL(a_div_start_idle, clk, rst, cmd.div_start, !status.div_busy, "divider restarted while busy")
  `ASSERT_NEXT(a_accept_then_busy, clk, rst, item_valid && item_ready, !item_ready, "second request taken at once")
  `ASSERT_NEXT(a_load_shows_result, clk, rst, cmd.load_out, result_valid, "loaded result not presented")

endmodule

`default_nettype wire

// ===== design/cma_div.sv =====
// Iterative rounding divider: signed window sum over an unsigned sample count.
// One quotient bit per cycle, rounding to nearest with ties away from zero; uses cma_pkg.
`default_nettype none

module cma_div #(
  parameter int CNT_W = 6,
  parameter int SUM_W = 37
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [SUM_W-1:0]            sum,
  input  logic        [CNT_W-1:0]            count,
  output logic                               busy,
  output logic                               done,
  output logic signed [cma_pkg::DATA_W-1:0]  quotient
);
  import cma_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [STEP_W-1:0] steps;
  logic [SUM_W-1:0]  dq;
  logic [SUM_W-1:0]  mag;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  divisor;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              neg;
  logic              qbit;
  logic [DATA_W-1:0] qlow;

  always_comb begin
    mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    trial = {rem, dq[SUM_W-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = (trial >= {1'b0, divisor});
    qlow  = dq[DATA_W-1:0];
    quotient = neg ? -qlow : qlow;
  end

  // The dividend register fills with quotient bits from the bottom as it shifts out.
  always_ff @(posedge clk) begin
    if (start) begin
      dq      <= mag + SUM_W'(count >> 1);
      rem     <= '0;
      divisor <= count;
      neg     <= sum[SUM_W-1];
    end else if (busy) begin
      dq  <= {dq[SUM_W-2:0], qbit};
      rem <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/cma_datapath.sv =====
// Datapath of the centred moving average: sample store, window accumulator,
// divider and output register. Driven by cma_ctrl; uses cma_pkg and cma_div.
`default_nettype none

module cma_datapath #(
  parameter int MAX_WINDOW = cma_pkg::MAX_WINDOW_DEF,
  parameter int CNT_W      = 6,
  parameter int SUM_W      = 37
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cma_pkg::in_item_t     item,
  input  cma_pkg::dp_cmd_t      cmd,
  input  logic [CNT_W-1:0]      div_count,
  output cma_pkg::dp_status_t   status,
  output logic                  result_valid,
  input  logic                  result_ready,
  output cma_pkg::out_item_t    result
);
  import cma_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);

  logic [DATA_W-1:0]        store_mem [MAX_WINDOW];
  logic signed [DATA_W-1:0] sample_q;
  logic signed [DATA_W-1:0] rd_data;
  logic signed [SUM_W-1:0]  acc;
  logic [AW-1:0]            wp;
  logic [AW-1:0]            rd_ptr;
  out_item_t                out_q;
  logic                     div_busy;
  logic                     div_done;
  logic signed [DATA_W-1:0] quotient;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      store_mem[wp] <= sample_q;
    end
    if (cmd.read_en) begin
      rd_data <= store_mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_q <= item.sample;
    end
    if (cmd.add_en) begin
      acc <= acc + SUM_W'(rd_data);
    end else if (cmd.sum_start) begin
      acc <= '0;
    end
    if (cmd.load_out) begin
      out_q.average      <= cmd.pass_sel ? sample_q : quotient;
      out_q.last_average <= cmd.out_last;
    end
  end

  // The window is read newest first, walking backwards round the ring.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp           <= '0;
      rd_ptr       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.store) begin
        wp <= (wp == LAST_SLOT) ? '0 : wp + 1'b1;
      end
      if (cmd.sum_start) begin
        rd_ptr <= (wp == '0) ? LAST_SLOT : wp - 1'b1;
      end else if (cmd.read_en) begin
        rd_ptr <= (rd_ptr == '0) ? LAST_SLOT : rd_ptr - 1'b1;
      end
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  cma_div #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .sum      (acc),
    .count    (div_count),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  assign result          = out_q;
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;
  assign status.out_free = !result_valid || result_ready;

endmodule

`default_nettype wire

// ===== design/cma_ctrl.sv =====
// Controller of the centred moving average (uses cma_pkg): sequence counters and
// the state machine stepping the datapath: store, sum, divide and output, or bypass.
`default_nettype none

module cma_ctrl #(
  parameter int MAX_WINDOW = cma_pkg::MAX_WINDOW_DEF,
  parameter int CNT_W      = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [cma_pkg::CFG_W-1:0]  window_length,
  input  logic                       cfg_write,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic                       item_last,
  input  cma_pkg::dp_status_t        status,
  output cma_pkg::dp_cmd_t           cmd,
  output logic [CNT_W-1:0]           div_count
);
  import cma_pkg::*;

  localparam int WMAX = (MAX_WINDOW < WINDOW_MAX) ? MAX_WINDOW : WINDOW_MAX;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE,
    S_SUM_START,
    S_SUM,
    S_DIV,
    S_OUT,
    S_PASS
  } state_t;

  state_t           state;
  logic             seq_last;
  logic [CNT_W-1:0] seen;
  logic [CNT_W-1:0] emitted;
  logic [CNT_W-1:0] center;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] issued;
  logic             rd_pend;

  logic [CNT_W-1:0] w;
  logic [CNT_W-1:0] n_left;
  logic [CNT_W-1:0] n_right;
  logic [CNT_W-1:0] n_right_p1;
  logic [CNT_W-1:0] seen_next;
  logic [CNT_W-1:0] pend;
  logic [CNT_W-1:0] prior;
  logic [CNT_W-1:0] cnt_next;
  logic             short_window;

  always_comb begin
    if (int'(window_length) > WMAX) begin
      w = CNT_W'(WMAX);
    end else begin
      w = CNT_W'(window_length);
    end
    short_window = (window_length <= CFG_W'(1));
    n_left     = w >> 1;
    n_right    = (w - 1'b1) >> 1;
    n_right_p1 = n_right + 1'b1;
    seen_next  = (seen < w) ? seen + 1'b1 : seen;
    pend       = (seen_next < n_right_p1) ? seen_next : n_right_p1;
    prior      = (emitted < n_left) ? emitted : n_left;
    cnt_next   = center + 1'b1 + prior;
  end

  always_comb begin
    cmd         = '0;
    item_ready  = (state == S_IDLE);
    cmd.capture = item_valid && item_ready;
    case (state)
      S_STORE: begin
        cmd.store = 1'b1;
      end
      S_SUM_START: begin
        cmd.sum_start = 1'b1;
      end
      S_SUM: begin
        cmd.read_en   = (issued != cnt);
        cmd.add_en    = rd_pend;
        cmd.div_start = (issued == cnt) && !rd_pend;
      end
      S_OUT: begin
        cmd.load_out = status.out_free;
        cmd.out_last = seq_last && (center == '0);
      end
      S_PASS: begin
        cmd.load_out = status.out_free;
        cmd.pass_sel = 1'b1;
        cmd.out_last = seq_last;
      end
      default: begin
        cmd.store = 1'b0;
      end
    endcase
  end

  assign div_count = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      seq_last <= 1'b0;
      seen     <= '0;
      emitted  <= '0;
      center   <= '0;
      cnt      <= '0;
      issued   <= '0;
      rd_pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            seq_last <= item_last;
            state    <= short_window ? S_PASS : S_STORE;
          end
        end
        S_STORE: begin
          seen <= seen_next;
          // The final sample flushes every pending result, oldest centre first.
          if (seq_last) begin
            center <= pend - 1'b1;
            state  <= S_SUM_START;
          end else if (seen_next > n_right) begin
            center <= n_right;
            state  <= S_SUM_START;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SUM_START: begin
          cnt     <= cnt_next;
          issued  <= '0;
          rd_pend <= 1'b0;
          state   <= S_SUM;
        end
        S_SUM: begin
          rd_pend <= cmd.read_en;
          if (cmd.read_en) begin
            issued <= issued + 1'b1;
          end
          if (cmd.div_start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (status.div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (status.out_free) begin
            if (emitted < n_left) begin
              emitted <= emitted + 1'b1;
            end
            if (seq_last && (center != '0)) begin
              center <= center - 1'b1;
              state  <= S_SUM_START;
            end else begin
              if (seq_last) begin
                seen    <= '0;
                emitted <= '0;
              end
              state <= S_IDLE;
            end
          end
        end
        S_PASS: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // A new window length abandons the sequence in progress.
      if (cfg_write) begin
        seen    <= '0;
        emitted <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_centered_moving_average.sv =====
// Self-checking testbench for centered_moving_average: directed table, then random sequences
// under several idling patterns, checked against a behavioural predictor of the averages
// or the table's typed values. Depends on cma_pkg and the centered_moving_average RTL.
`default_nettype none

module tb_centered_moving_average;
  import cma_pkg::*;

  localparam int STORE_DEPTH   = MAX_WINDOW_DEF;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_ITEMS   = 63;
  localparam int HOLD_CYCLES   = 600;
  localparam logic [REG_IDX_W-1:0]  REG_UNUSED   = 1'b1;
  localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR  = {REG_WINDOW_LENGTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR  = {REG_UNUSED, 2'b00};

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_WINDOW, ROW_UNUSED_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] value;
    logic        last;
    logic        typed;
    logic [31:0] want;
  } row_t;

  localparam int NUM_ROWS = 26;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    // Single samples under the reset window, and windows 1 and 0, give the sample back.
    '{ROW_SAMPLE,     32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{ROW_SAMPLE,     32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{ROW_WINDOW,     32'd1,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
    '{ROW_SAMPLE,     32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ROW_WINDOW,     32'd0,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678},
    '{ROW_WINDOW,     32'd2,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{ROW_WINDOW,     32'd32,        1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'h8000_0000, 1'b1, 1'b0, 32'h0},
    // Oversized window, and halves that round away from zero.
    '{ROW_WINDOW,     32'd63,        1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'h0000_0002, 1'b1, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'hFFFF_FFFE, 1'b1, 1'b0, 32'h0},
    // A register write in the middle of a sequence drops it without output.
    '{ROW_WINDOW,     32'd3,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{ROW_WINDOW,     32'd3,         1'b0, 1'b0, 32'h0},
    '{ROW_UNUSED_REG, 32'd7,         1'b0, 1'b0, 32'h0},
    '{ROW_SAMPLE,     32'h0000_0009, 1'b1, 1'b1, 32'h0000_0009}
  };

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  item_valid;
  logic                  item_ready;
  in_item_t              item;
  logic                  result_valid;
  logic                  result_ready;
  out_item_t             result;

  // Predictor state.
  logic [CFG_W-1:0]        window_len;
  logic signed [DATA_W-1:0] sample_ring [STORE_DEPTH];
  int unsigned             wr_pos;
  int unsigned             seen_count;
  int unsigned             emitted_count;
  out_item_t               pending_averages [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_len;
  int unsigned mismatch_count;
  out_item_t   want_item;

  centered_moving_average u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic [31:0] rounded_mean(input longint total, input int unsigned count);
    longint mag;
    longint quot;
    mag  = (total < 0) ? -total : total;
    quot = (mag + longint'(count / 2)) / longint'(count);
    if (total < 0) begin
      quot = -quot;
    end
    return quot[31:0];
  endfunction

  // Average centred 'center' places back from the newest stored sample.
  task automatic emit_average(input int unsigned center, input int unsigned n_left,
                              input logic last);
    int unsigned before_cnt;
    int unsigned count;
    longint      total;
    out_item_t   avg;
    before_cnt = (emitted_count < n_left) ? emitted_count : n_left;
    count      = center + 1 + before_cnt;
    total      = 0;
    for (int unsigned k = 0; k < count; k++) begin
      total += longint'(sample_ring[(wr_pos + STORE_DEPTH - 1 - k) % STORE_DEPTH]);
    end
    avg.average      = rounded_mean(total, count);
    avg.last_average = last;
    pending_averages.push_back(avg);
    if (emitted_count < n_left) begin
      emitted_count++;
    end
  endtask

  task automatic predict_averages(input in_item_t req);
    int unsigned w;
    int unsigned n_left;
    int unsigned n_right;
    int unsigned flush_cnt;
    out_item_t   echo;
    if (window_len <= 1) begin
      echo.average      = req.sample;
      echo.last_average = req.last_sample;
      pending_averages.push_back(echo);
    end else begin
      w       = (window_len > STORE_DEPTH) ? STORE_DEPTH : window_len;
      n_left  = w / 2;
      n_right = (w - 1) / 2;
      sample_ring[wr_pos] = req.sample;
      wr_pos = (wr_pos + 1) % STORE_DEPTH;
      if (seen_count < w) begin
        seen_count++;
      end
      if (!req.last_sample) begin
        if (seen_count > n_right) begin
          emit_average(n_right, n_left, 1'b0);
        end
      end else begin
        // The final sample flushes everything still pending, newest last.
        flush_cnt = (seen_count < n_right + 1) ? seen_count : n_right + 1;
        for (int unsigned c = flush_cnt; c > 0; c--) begin
          emit_average(c - 1, n_left, c == 1);
        end
        seen_count    = 0;
        emitted_count = 0;
      end
    end
  endtask

  task automatic send_item(input in_item_t req);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) begin
        @(negedge clk);
      end
    end
    item_valid <= 1'b1;
    item       <= req;
    @(posedge clk);
    while (!item_ready) begin
      @(posedge clk);
    end
    predict_averages(req);
  endtask

  // Drops the request and waits for every expected average, then 'extra' cycles more.
  task automatic settle(input int unsigned extra);
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_averages.size() != 0) begin
      @(posedge clk);
    end
    repeat (extra) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    if (addr[APB_ADDR_W-1:2] == REG_WINDOW_LENGTH) begin
      window_len    = data[CFG_W-1:0];
      seen_count    = 0;
      emitted_count = 0;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check_window();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= WINDOW_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    if (prdata !== APB_DATA_W'(window_len)) begin
      report_mismatch($sformatf("window_length read %0h, written %0h", prdata, window_len));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_window(input logic [31:0] value);
    settle(SETTLE_CYCLES);
    apb_write(WINDOW_ADDR, value);
    apb_check_window();
  endtask

  function automatic logic [31:0] rand_sample();
    logic [31:0] s;
    case ($urandom_range(3))
      0: s = $urandom_range(2000) - 1000;
      1: begin
        case ($urandom_range(3))
          0:       s = 32'h7FFF_FFFF;
          1:       s = 32'h8000_0000;
          2:       s = 32'h0000_0000;
          default: s = 32'hFFFF_FFFF;
        endcase
      end
      default: s = $urandom();
    endcase
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_averages.size() == 0) begin
        report_mismatch($sformatf("unexpected average %0h last %0b",
                                  result.average, result.last_average));
      end else begin
        want_item = pending_averages.pop_front();
        if (result.average !== want_item.average) begin
          report_mismatch($sformatf("average %0h, expected %0h",
                                    result.average, want_item.average));
        end
        if (result.last_average !== want_item.last_average) begin
          report_mismatch($sformatf("last_average %0b, expected %0b",
                                    result.last_average, want_item.last_average));
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when one is asked for.
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_len > 0) begin
        result_ready <= 1'b0;
        repeat (hold_off_len) @(negedge clk);
        hold_off_len = 0;
      end
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    in_item_t    req;
    int unsigned sent;
    int unsigned seq_len;
    int unsigned eff_w;
    logic [31:0] win;
    out_item_t   typed_item;

    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    item_valid     = 1'b0;
    item           = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_len   = 0;
    mismatch_count = 0;
    window_len     = WINDOW_RESET;
    wr_pos         = 0;
    seen_count     = 0;
    emitted_count  = 0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      sample_ring[i] = '0;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++) begin
      case (DIRECTED[r].kind)
        ROW_WINDOW: set_window(DIRECTED[r].value);
        ROW_UNUSED_REG: begin
          settle(SETTLE_CYCLES);
          apb_write(UNUSED_ADDR, DIRECTED[r].value);
          apb_check_window();
        end
        default: begin
          req.sample      = DIRECTED[r].value;
          req.last_sample = DIRECTED[r].last;
          send_item(req);
          if (DIRECTED[r].typed) begin
            // These rows give exactly one average, known without the predictor.
            void'(pending_averages.pop_back());
            typed_item.average      = DIRECTED[r].want;
            typed_item.last_average = DIRECTED[r].last;
            pending_averages.push_back(typed_item);
          end
        end
      endcase
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      case (ph)
        0:       win = 2;
        1:       win = 32;
        2:       win = 63;
        3:       win = 0;
        4:       win = 1;
        5:       win = 3;
        6:       win = $urandom_range(31, 4);
        default: win = $urandom_range(63, 0);
      endcase
      set_window(win);
      eff_w = (win > STORE_DEPTH) ? STORE_DEPTH : ((win < 1) ? 1 : win);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) begin
          seq_len = $urandom_range(3, 1);
        end else begin
          seq_len = $urandom_range(2 * eff_w + 4, 1);
        end
        if (seq_len > PHASE_ITEMS - sent) begin
          seq_len = PHASE_ITEMS - sent;
        end
        for (int k = 0; k < seq_len; k++) begin
          if (ph == 0 && sent == 10) begin
            hold_off_len = HOLD_CYCLES;
          end
          if (ph == 1 && sent == 30) begin
            settle(0);
          end
          req.sample      = rand_sample();
          req.last_sample = (k == seq_len - 1);
          send_item(req);
          sent++;
        end
      end
    end

    settle(SETTLE_CYCLES);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/cma_pkg.sv
design/cma_div.sv
design/cma_datapath.sv
design/cma_ctrl.sv
design/centered_moving_average.sv
test/tb_centered_moving_average.sv
